// ===== hdl/i2cra_pkg.sv =====
// Shared types and constants for the I2C register access master.
package i2cra_pkg;

    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_S0   = 5'd1,
        ST_S1   = 5'd2,
        ST_S2   = 5'd3,
        ST_S3   = 5'd4,
        ST_T0   = 5'd5,
        ST_T1   = 5'd6,
        ST_T2   = 5'd7,
        ST_T3   = 5'd8,
        ST_A0   = 5'd9,
        ST_A1   = 5'd10,
        ST_A2   = 5'd11,
        ST_GAP  = 5'd12,
        ST_R0   = 5'd13,
        ST_R1   = 5'd14,
        ST_R2   = 5'd15,
        ST_R3   = 5'd16,
        ST_N0   = 5'd17,
        ST_N1   = 5'd18,
        ST_N2   = 5'd19,
        ST_P0   = 5'd20,
        ST_P1   = 5'd21,
        ST_P2   = 5'd22
    } t_seq_state;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_GAP_PHASES = 2'd2;

    localparam logic [15:0] PHASE_TICKS_RST     = 16'd160;
    localparam logic [15:0] ACK_WAIT_LIMIT_RST  = 16'd280;
    localparam logic [7:0]  READ_GAP_PHASES_RST = 8'd5;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] ack_wait_limit;
        logic [7:0]  read_gap_phases;
    } t_cfg;

    typedef struct packed {
        logic       cmd_valid;
        logic       opcode;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
    } t_bus_res;

endpackage

// ===== hdl/i2cra_cfg.sv =====
// Configuration register file for the I2C register access master.
module i2cra_cfg
    import i2cra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks     <= PHASE_TICKS_RST;
            r_cfg.ack_wait_limit  <= ACK_WAIT_LIMIT_RST;
            r_cfg.read_gap_phases <= READ_GAP_PHASES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_PHASE_TICKS: begin
                    r_cfg.phase_ticks <= i_cfg_data;
                end
                CFG_ACK_WAIT_LIMIT: begin
                    r_cfg.ack_wait_limit <= i_cfg_data;
                end
                CFG_READ_GAP_PHASES: begin
                    r_cfg.read_gap_phases <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/i2cra_seq.sv =====
// Bus sequencer: advances the I2C state by one clock per step beat.
module i2cra_seq
    import i2cra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_cmd     i_cmd,
    input  t_cfg     i_cfg,
    output t_bus_res o_res
);

    t_seq_state r_state, n_state;
    logic [15:0] r_phase, n_phase;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_ack_wait, n_ack_wait;
    logic [7:0]  r_gap, n_gap;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic        r_read_mode, n_read_mode;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_rd_result, n_rd_result;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    logic        go;
    logic        done;
    t_seq_state  tgt;
    logic [15:0] ticks;
    logic [15:0] pc;
    logic [15:0] awc;
    logic [3:0]  bc;
    logic [7:0]  gc;
    logic [7:0]  sh;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_ack_wait  = r_ack_wait;
        n_gap       = r_gap;
        n_byte_idx  = r_byte_idx;
        n_read_mode = r_read_mode;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_data      = r_data;
        n_rd_result = r_rd_result;
        n_scl       = r_scl;
        n_sda       = r_sda;
        go          = 1'b0;
        done        = 1'b0;
        tgt         = ST_IDLE;
        ticks       = (i_cfg.phase_ticks == 16'd0) ? 16'd1 : i_cfg.phase_ticks;
        pc          = r_phase + 16'd1;
        awc         = r_ack_wait + 16'd1;
        bc          = r_bit + 4'd1;
        gc          = r_gap + 8'd1;
        sh          = (r_state == ST_R2) ? {r_shift[6:0], i_cmd.sda_in} : r_shift;

        // Event part: decide which phase, if any, is entered this cycle.
        if (r_state == ST_IDLE) begin
            if (i_cmd.cmd_valid) begin
                n_read_mode = (i_cmd.opcode == OP_READ);
                n_addr      = i_cmd.dev_addr;
                n_reg       = i_cmd.reg_addr;
                n_data      = i_cmd.wr_data;
                n_byte_idx  = 2'd0;
                go          = 1'b1;
                tgt         = ST_S0;
            end
        end else if (r_state == ST_A1) begin
            if (!i_cmd.sda_in) begin
                go  = 1'b1;
                tgt = ST_A2;
            end else begin
                n_ack_wait = awc;
                if (awc >= i_cfg.ack_wait_limit) begin
                    go  = 1'b1;
                    tgt = ST_A2;
                end
            end
        end else begin
            n_phase = pc;
            if (pc >= ticks) begin
                n_shift = sh;
                go      = 1'b1;
                case (r_state)
                    ST_S0: tgt = ST_S1;
                    ST_S1: tgt = ST_S2;
                    ST_S2: tgt = ST_S3;
                    ST_S3: begin
                        // The repeated start of a read carries the read address.
                        n_shift = (r_byte_idx == 2'd2) ? r_addr + 8'd1 : r_addr;
                        n_bit   = 4'd0;
                        tgt     = ST_T0;
                    end
                    ST_T0: tgt = ST_T1;
                    ST_T1: tgt = ST_T2;
                    ST_T2: begin
                        n_bit   = bc;
                        n_shift = {sh[6:0], 1'b0};
                        tgt     = (bc >= BITS_PER_BYTE) ? ST_T3 : ST_T0;
                    end
                    ST_T3: tgt = ST_A0;
                    ST_A0: tgt = ST_A1;
                    ST_A2: begin
                        if (r_byte_idx == 2'd0) begin
                            n_byte_idx = 2'd1;
                            n_shift    = r_reg;
                            n_bit      = 4'd0;
                            tgt        = ST_T0;
                        end else if (r_byte_idx == 2'd1) begin
                            n_byte_idx = 2'd2;
                            if (r_read_mode) begin
                                tgt = ST_S0;
                            end else begin
                                n_shift = r_data;
                                n_bit   = 4'd0;
                                tgt     = ST_T0;
                            end
                        end else begin
                            tgt = r_read_mode ? ST_GAP : ST_P0;
                        end
                    end
                    ST_GAP: begin
                        n_gap = gc;
                        if (gc >= i_cfg.read_gap_phases) begin
                            tgt = ST_R0;
                        end else begin
                            go      = 1'b0;
                            n_phase = 16'd0;
                        end
                    end
                    ST_R0: tgt = ST_R1;
                    ST_R1: tgt = ST_R2;
                    ST_R2: tgt = ST_R3;
                    ST_R3: begin
                        n_bit = bc;
                        if (bc >= BITS_PER_BYTE) begin
                            n_rd_result = sh;
                            tgt         = ST_N0;
                        end else begin
                            tgt = ST_R2;
                        end
                    end
                    ST_N0: tgt = ST_N1;
                    ST_N1: tgt = ST_N2;
                    ST_N2: tgt = ST_P0;
                    ST_P0: tgt = ST_P1;
                    ST_P1: tgt = ST_P2;
                    ST_P2: begin
                        go      = 1'b0;
                        done    = 1'b1;
                        n_state = ST_IDLE;
                        n_phase = 16'd0;
                    end
                    default: begin
                        go      = 1'b0;
                        n_state = ST_IDLE;
                        n_phase = 16'd0;
                    end
                endcase
            end
        end

        // Entry part: set the line levels of the phase being entered.
        if (go) begin
            n_state = tgt;
            n_phase = 16'd0;
            case (tgt)
                ST_S0: n_sda = 1'b1;
                ST_S1: n_scl = 1'b1;
                ST_S2: n_sda = 1'b0;
                ST_S3: n_scl = 1'b0;
                ST_T0: begin
                    n_scl = 1'b0;
                    n_sda = n_shift[7];
                end
                ST_T1: n_scl = 1'b1;
                ST_T2: n_scl = 1'b0;
                ST_T3: n_sda = 1'b1;
                ST_A0: n_scl = 1'b1;
                ST_A1: begin
                    n_ack_wait = 16'd0;
                    // With no wait allowed the ack slot closes at once.
                    if (i_cfg.ack_wait_limit == 16'd0) begin
                        n_state = ST_A2;
                        n_scl   = 1'b0;
                    end
                end
                ST_A2: n_scl = 1'b0;
                ST_GAP: begin
                    n_gap = 8'd0;
                    if (i_cfg.read_gap_phases == 8'd0) begin
                        n_state = ST_R0;
                        n_scl   = 1'b0;
                        n_bit   = 4'd0;
                        n_shift = 8'd0;
                    end
                end
                ST_R0: begin
                    n_scl   = 1'b0;
                    n_bit   = 4'd0;
                    n_shift = 8'd0;
                end
                ST_R1: n_sda = 1'b1;
                ST_R2: n_scl = 1'b1;
                ST_R3: n_scl = 1'b0;
                ST_N0: n_sda = 1'b1;
                ST_N1: n_scl = 1'b1;
                ST_N2: n_scl = 1'b0;
                ST_P0: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                ST_P1: n_scl = 1'b1;
                ST_P2: n_sda = 1'b1;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 16'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_ack_wait  <= 16'd0;
            r_gap       <= 8'd0;
            r_byte_idx  <= 2'd0;
            r_read_mode <= 1'b0;
            r_addr      <= 8'd0;
            r_reg       <= 8'd0;
            r_data      <= 8'd0;
            r_rd_result <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_step) begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_ack_wait  <= n_ack_wait;
            r_gap       <= n_gap;
            r_byte_idx  <= n_byte_idx;
            r_read_mode <= n_read_mode;
            r_addr      <= n_addr;
            r_reg       <= n_reg;
            r_data      <= n_data;
            r_rd_result <= n_rd_result;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    // The result of a step shows the levels after that step's update.
    always_comb begin
        o_res.scl_out  = n_scl;
        o_res.sda_out  = n_sda;
        o_res.busy_res = (n_state != ST_IDLE);
        o_res.done_res = done;
        o_res.rd_data  = n_rd_result;
    end

endmodule

// ===== hdl/i2c_register_access_master.sv =====
// Top level of the I2C register access master: input register, sequencer, result register.
// Each input beat is one clock of the I2C bus sequencer and yields exactly one result beat
// with the SCL/SDA drive levels, busy and done flags and the last byte read. The block takes
// one beat per cycle unless o_stall holds it; a beat's result passes the input register, then
// the sequencer's next-state logic into the result register, and a stalled result stops the
// next beat only while the input register is still full. Bus timing follows from the beat
// rate: every SCL/SDA phase but the ack slot lasts phase_ticks beats (zero counts as one), and
// an ack slot lasts until SDA reads low or ack_wait_limit beats pass. Configuration writes are
// taken on any cycle and should be made while no transaction is running.
module i2c_register_access_master
    import i2cra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd_valid,
    input  logic                  i_opcode,
    input  logic [7:0]            i_dev_addr,
    input  logic [7:0]            i_reg_addr,
    input  logic [7:0]            i_wr_data,
    input  logic                  i_sda_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_scl_out,
    output logic                  o_sda_out,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rd_data
);

    t_cfg     cfg;
    t_bus_res seq_res;
    t_cmd     r_in;
    logic     r_in_valid;
    t_bus_res r_out;
    logic     r_out_valid;
    logic     advance;
    logic     in_beat;

    i2cra_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A held beat moves on when the result register is empty or being emptied.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_beat = i_valid && !o_stall;

    i2cra_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (r_in),
        .i_cfg   (cfg),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in.cmd_valid <= i_cmd_valid;
            r_in.opcode    <= i_opcode;
            r_in.dev_addr  <= i_dev_addr;
            r_in.reg_addr  <= i_reg_addr;
            r_in.wr_data   <= i_wr_data;
            r_in.sda_in    <= i_sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_scl_out  = r_out.scl_out;
    assign o_sda_out  = r_out.sda_out;
    assign o_busy_res = r_out.busy_res;
    assign o_done_res = r_out.done_res;
    assign o_rd_data  = r_out.rd_data;

endmodule

// ===== hdl/i2cra_chk.sv =====
// Port-level checker for the I2C register access master, bound to the top level.
module i2cra_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rd_data
);

    // A stop completes with both lines released and the sequencer idle.
    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_scl_out && o_sda_out && !o_busy_res)
        else $error("done beat without released lines or with busy set");

    // The input side only stalls behind a result that is itself stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the result side can move");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scl_out) && $stable(o_sda_out)
            && $stable(o_busy_res) && $stable(o_done_res) && $stable(o_rd_data))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown right after reset");

endmodule

bind i2c_register_access_master i2cra_chk u_i2cra_chk (.*);
